// File: src/eaf_pkg.sv
// Shared types and constants of the edge alpha fade pipeline.
package eaf_pkg;

  localparam int CoordW   = 12;
  localparam int DimW     = 13;
  localparam int ByteW    = 8;
  localparam int NumEdges = 4;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  // Largest factor that still fades a pixel.
  localparam int FactorMax = 255;

  // Edge slots, in the order the fades are applied.
  localparam logic [1:0] EdgeBottom = 2'd0;
  localparam logic [1:0] EdgeTop    = 2'd1;
  localparam logic [1:0] EdgeLeft   = 2'd2;
  localparam logic [1:0] EdgeRight  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegEdgeMask   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFadeStep   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 8'd2;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 8'd3;

  // Channel bytes: blue, green, red, alpha.
  typedef logic [3:0][ByteW-1:0] px_t;

  // Live configuration seen by the stages; dimensions stored as last index.
  typedef struct packed {
    logic [NumEdges-1:0] edge_mask;
    logic [ByteW-1:0]    fade_step;
    logic [DimW-1:0]     w_last;
    logic [DimW-1:0]     h_last;
  } cfg_t;

  // Pixel with its distance to each edge.
  typedef struct packed {
    px_t                           px;
    logic [NumEdges-1:0][DimW-1:0] distance;
  } dist_t;

  // Pixel with its four factors and apply flags.
  typedef struct packed {
    px_t                            px;
    logic [NumEdges-1:0][ByteW-1:0] fac;
    logic [NumEdges-1:0]            apply;
  } fac_t;

endpackage

// File: src/eaf_if.sv
// Handshake channels of the edge alpha fade block.
interface eaf_in_if;
  logic                        valid;
  logic                        ready;
  logic [eaf_pkg::CoordW-1:0]  column;
  logic [eaf_pkg::CoordW-1:0]  row;
  logic [eaf_pkg::ByteW-1:0]   blue;
  logic [eaf_pkg::ByteW-1:0]   green;
  logic [eaf_pkg::ByteW-1:0]   red;
  logic [eaf_pkg::ByteW-1:0]   alpha;

  modport source (output valid, column, row, blue, green, red, alpha, input ready);
  modport sink   (input valid, column, row, blue, green, red, alpha, output ready);
endinterface

interface eaf_out_if;
  logic                      valid;
  logic                      ready;
  logic [eaf_pkg::ByteW-1:0] out_blue;
  logic [eaf_pkg::ByteW-1:0] out_green;
  logic [eaf_pkg::ByteW-1:0] out_red;
  logic [eaf_pkg::ByteW-1:0] out_alpha;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface eaf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [eaf_pkg::CfgIdxW-1:0]  index;
  logic [eaf_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/eaf_dist.sv
// Clamp stage: clamps the coordinates and forms the distance to each edge.
module eaf_dist (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eaf_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [eaf_pkg::CoordW-1:0] column_i,
  input  logic [eaf_pkg::CoordW-1:0] row_i,
  input  eaf_pkg::px_t   px_i,
  output logic           valid_o,
  input  logic           ready_i,
  output eaf_pkg::dist_t data_o
);
  import eaf_pkg::*;

  logic            valid_q;
  dist_t           data_d, data_q;
  logic [DimW-1:0] col_ext, row_ext, col_c, row_c;

  // Clamp to the last column and row, then measure to each edge
  always_comb begin
    col_ext = {1'b0, column_i};
    row_ext = {1'b0, row_i};
    col_c   = (col_ext > cfg_i.w_last) ? cfg_i.w_last : col_ext;
    row_c   = (row_ext > cfg_i.h_last) ? cfg_i.h_last : row_ext;
    data_d.px                   = px_i;
    data_d.distance[EdgeBottom] = cfg_i.h_last - row_c;
    data_d.distance[EdgeTop]    = row_c;
    data_d.distance[EdgeLeft]   = col_c;
    data_d.distance[EdgeRight]  = cfg_i.w_last - col_c;
  end

  assign ready_o = !valid_q || ready_i;

  // Advance when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/eaf_factor.sv
// Factor stage: multiplies each distance by the step and flags usable factors.
module eaf_factor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eaf_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  eaf_pkg::dist_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output eaf_pkg::fac_t  data_o
);
  import eaf_pkg::*;

  logic                                valid_q;
  fac_t                                data_d, data_q;
  logic [NumEdges-1:0][2*ByteW-1:0]    prod;

  // Form the factor per edge; a distance past the byte range fades only at zero step
  always_comb begin
    data_d.px = data_i.px;
    for (int k = 0; k < NumEdges; k++) begin
      prod[k] = data_i.distance[k][ByteW-1:0] * cfg_i.fade_step;
      data_d.fac[k]   = prod[k][ByteW-1:0];
      data_d.apply[k] = cfg_i.edge_mask[k]
                        && ((cfg_i.fade_step == '0)
                            || ((data_i.distance[k] <= DimW'(FactorMax))
                                && (prod[k] <= (2*ByteW)'(FactorMax))));
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Advance when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/eaf_scale.sv
// Scale stage: applies one edge's factor to all four channel bytes.
module eaf_scale #(
  parameter int EDGE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  eaf_pkg::fac_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output eaf_pkg::fac_t data_o
);
  import eaf_pkg::*;

  logic                          valid_q;
  fac_t                          data_d, data_q;
  logic [3:0][2*ByteW-1:0]       prod;

  // Scale each byte by factor/256 when this edge applies
  always_comb begin
    data_d = data_i;
    for (int c = 0; c < 4; c++) begin
      prod[c] = data_i.px[c] * data_i.fac[EDGE];
      if (data_i.apply[EDGE]) begin
        data_d.px[c] = prod[c][2*ByteW-1:ByteW];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Advance when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/edge_alpha_fade.sv
// Top level of the edge alpha fade pipeline.
//
//   port    dir   carries                                   word
//   pix_i   sink  column, row, blue, green, red, alpha      one pixel
//   res_o   src   out_blue, out_green, out_red, out_alpha   one faded pixel
//   cfg_i   sink  index, data                               one register write
//
// One pixel per clock while the output does not stall; the stages are clamp/distance,
// factor, then one 8x8 multiply stage per edge (bottom, top, left, right).
// Each stage has its own valid bit and ready = !valid || downstream ready, so
// bubbles collapse and a stall at the output backs up stage by stage.
// Reset clears the valid bits and loads the register reset values.
// Configuration writes are always taken; the last stage is the output register.
module edge_alpha_fade #(
  parameter int MAX_DIM = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eaf_in_if.sink    pix_i,
  eaf_out_if.source res_o,
  eaf_cfg_if.sink   cfg_i
);
  import eaf_pkg::*;

  localparam int NumStages = 2 + NumEdges;
  localparam int OccW      = $clog2(NumStages + 1);

  // Effective dimension minus one: zero reads as one, large saturates
  function automatic logic [DimW-1:0] dim_last(input logic [DimW-1:0] d);
    logic [31:0] e;
    if (d == '0) begin
      e = 32'd1;
    end else if (32'(d) > 32'(MAX_DIM)) begin
      e = 32'(MAX_DIM);
    end else begin
      e = 32'(d);
    end
    return DimW'(e - 32'd1);
  endfunction

  logic [NumEdges-1:0] edge_mask_q;
  logic [ByteW-1:0]    fade_step_q;
  logic [DimW-1:0]     w_last_q, h_last_q;
  cfg_t                cfg;

  // Take register writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mask_q <= '0;
      fade_step_q <= ByteW'(16);
      w_last_q    <= dim_last(DimW'(4096));
      h_last_q    <= dim_last(DimW'(4096));
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegEdgeMask:    edge_mask_q <= cfg_i.data[NumEdges-1:0];
        RegFadeStep:    fade_step_q <= cfg_i.data[ByteW-1:0];
        RegImageWidth:  w_last_q    <= dim_last(cfg_i.data[DimW-1:0]);
        RegImageHeight: h_last_q    <= dim_last(cfg_i.data[DimW-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg.edge_mask = edge_mask_q;
  assign cfg.fade_step = fade_step_q;
  assign cfg.w_last    = w_last_q;
  assign cfg.h_last    = h_last_q;

  // Stage wiring
  px_t   in_px;
  logic  d_valid, d_ready;
  dist_t d_data;
  logic  [NumEdges:0] sc_valid, sc_ready;
  fac_t  sc_data [NumEdges+1];

  assign in_px = {pix_i.alpha, pix_i.red, pix_i.green, pix_i.blue};

  eaf_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (pix_i.valid),
    .ready_o  (pix_i.ready),
    .column_i (pix_i.column),
    .row_i    (pix_i.row),
    .px_i     (in_px),
    .valid_o  (d_valid),
    .ready_i  (d_ready),
    .data_o   (d_data)
  );

  eaf_factor u_factor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .data_i  (d_data),
    .valid_o (sc_valid[0]),
    .ready_i (sc_ready[0]),
    .data_o  (sc_data[0])
  );

  // One scale stage per edge, in bottom, top, left, right order
  for (genvar g = 0; g < NumEdges; g++) begin : g_scale
    eaf_scale #(
      .EDGE (g)
    ) u_scale (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sc_valid[g]),
      .ready_o (sc_ready[g]),
      .data_i  (sc_data[g]),
      .valid_o (sc_valid[g+1]),
      .ready_i (sc_ready[g+1]),
      .data_o  (sc_data[g+1])
    );
  end

  // Drive the result channel from the last stage
  assign res_o.valid        = sc_valid[NumEdges];
  assign sc_ready[NumEdges] = res_o.ready;
  assign res_o.out_blue     = sc_data[NumEdges].px[0];
  assign res_o.out_green    = sc_data[NumEdges].px[1];
  assign res_o.out_red      = sc_data[NumEdges].px[2];
  assign res_o.out_alpha    = sc_data[NumEdges].px[3];

  // Track words in flight for checking
  logic [NumStages-1:0] stage_valid;
  logic [OccW-1:0]      occ_d, occ_q;
  logic                 in_acc, out_acc;

  assign stage_valid = {sc_valid, d_valid};
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign out_acc     = res_o.valid && res_o.ready;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + OccW'(1);
    end else if (out_acc && !in_acc) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Every accepted word sits in exactly one stage until delivered
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) == 32'($countones(stage_valid)))
    else $error("pipeline occupancy does not match words in flight");

  // Input is held off only when every stage is full and the output stalls
  a_ready_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready == (!(&stage_valid) || res_o.ready))
    else $error("input ready does not follow pipeline fill");

  // A word accepted into an empty pipeline is registered in the first stage
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && occ_q == '0 && !res_o.valid) |=> d_valid)
    else $error("accepted word missing from first stage");

endmodule
